[rtl/wsts_pkg.sv]
// ----------------------------------------------------------------------------
// wsts_pkg
// Shared widths, codes and request/result types of the sum-tree sampler.
// ----------------------------------------------------------------------------
package wsts_pkg;

  localparam int unsigned LeavesDef = 256;
  localparam int unsigned LeafW     = 8;
  localparam int unsigned WeightW   = 24;
  localparam int unsigned SumW      = 32;
  localparam int unsigned CountW    = 9;

  localparam logic [CountW-1:0] CountRst = 9'd256;

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    action_e              action;
    logic [LeafW-1:0]     leaf;
    logic [WeightW-1:0]   weight;
    logic [SumW-1:0]      target;
  } req_t;

  typedef struct packed {
    logic [LeafW-1:0]     leaf_index;
    logic [WeightW-1:0]   leaf_weight;
    logic [SumW-1:0]      total_sum;
    logic                 beyond_total;
    logic                 bad_index;
  } res_t;

endpackage

[rtl/wsts_item_if.sv]
// ----------------------------------------------------------------------------
// wsts_item_if
// Request channel of the sum-tree sampler: valid/ready plus one action.
// ----------------------------------------------------------------------------
interface wsts_item_if;
  import wsts_pkg::*;

  logic                 valid;
  logic                 ready;
  action_e              action;
  logic [LeafW-1:0]     leaf;
  logic [WeightW-1:0]   weight;
  logic [SumW-1:0]      target;

  modport source (output valid, action, leaf, weight, target, input ready);
  modport sink   (input valid, action, leaf, weight, target, output ready);
endinterface

[rtl/wsts_result_if.sv]
// ----------------------------------------------------------------------------
// wsts_result_if
// Result channel of the sum-tree sampler: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface wsts_result_if;
  import wsts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [LeafW-1:0]     leaf_index;
  logic [WeightW-1:0]   leaf_weight;
  logic [SumW-1:0]      total_sum;
  logic                 beyond_total;
  logic                 bad_index;

  modport source (output valid, leaf_index, leaf_weight, total_sum, beyond_total,
                  bad_index, input ready);
  modport sink   (input valid, leaf_index, leaf_weight, total_sum, beyond_total,
                  bad_index, output ready);
endinterface

[rtl/weighted_sum_tree_sampler.sv]
// ----------------------------------------------------------------------------
// weighted_sum_tree_sampler
// Sum tree over leaf weights with update, weighted search, read and clear.
//
//   port          dir   kind          contents
//   item_i        in    valid/ready   action, leaf, weight, target
//   result_o      out   valid/ready   leaf_index, leaf_weight, total_sum,
//                                     beyond_total, bad_index
//   cfg_we_i/..   in    write only    leaf_count
//
// One tree node is read per cycle through one RAM read port. Update and
// search walk the tree level by level; read and a search beyond the total
// read one leaf, a bad index goes straight to the result, and clear sweeps
// the whole node store. ready returns with result_o.valid. After reset a
// clearing pass over the whole node store holds item_i.ready low.
// ----------------------------------------------------------------------------
module weighted_sum_tree_sampler #(
  parameter int unsigned LEAVES = wsts_pkg::LeavesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsts_pkg::CountW-1:0]   cfg_wdata_i,
  wsts_item_if.sink                     item_i,
  wsts_result_if.source                 result_o
);
  import wsts_pkg::*;

  localparam int unsigned CW = $clog2(LEAVES + 1);

  logic [CountW-1:0] leaf_count_q;
  logic [31:0]       lc_ext;
  logic [31:0]       n_ext;
  logic [CW-1:0]     count;
  req_t              req;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;
  logic              out_free;
  logic              seq_ready;
  logic              seq_done;
  logic              start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= CountRst;
    end else if (cfg_we_i) begin
      leaf_count_q <= cfg_wdata_i;
    end
  end

  // clamp the active count to 1..LEAVES
  assign lc_ext = 32'(leaf_count_q);
  always_comb begin
    priority if (lc_ext == 32'd0) begin
      n_ext = 32'd1;
    end else if (lc_ext > 32'(LEAVES)) begin
      n_ext = 32'(LEAVES);
    end else begin
      n_ext = lc_ext;
    end
  end
  assign count = n_ext[CW-1:0];

  assign req.action = item_i.action;
  assign req.leaf   = item_i.leaf;
  assign req.weight = item_i.weight;
  assign req.target = item_i.target;

  assign item_i.ready = seq_ready;
  assign start        = item_i.valid && seq_ready;
  assign out_free     = !out_valid_q || result_o.ready;

  wsts_seq #(
    .LEAVES (LEAVES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .count_i    (count),
    .out_free_i (out_free),
    .ready_o    (seq_ready),
    .done_o     (seq_done),
    .res_o      (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.leaf_index   = out_q.leaf_index;
  assign result_o.leaf_weight  = out_q.leaf_weight;
  assign result_o.total_sum    = out_q.total_sum;
  assign result_o.beyond_total = out_q.beyond_total;
  assign result_o.bad_index    = out_q.bad_index;

  a_busy_after_transfer: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready
  ) else $error("input ready right after an accepted transfer");

  a_flags_exclusive: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !(result_o.beyond_total && result_o.bad_index)
  ) else $error("beyond_total and bad_index both set");

  a_done_loads_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    seq_done |=> result_o.valid
  ) else $error("finished result not presented");

endmodule

[rtl/wsts_ram.sv]
// ----------------------------------------------------------------------------
// wsts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/wsts_alu.sv]
// ----------------------------------------------------------------------------
// wsts_alu
// Shared 32-bit add/subtract unit with borrow out, used for every update
// difference, path add, search compare and remainder step.
// ----------------------------------------------------------------------------
module wsts_alu (
  input  wsts_pkg::alu_op_e          op_i,
  input  logic [wsts_pkg::SumW-1:0]  a_i,
  input  logic [wsts_pkg::SumW-1:0]  b_i,
  output logic [wsts_pkg::SumW-1:0]  y_o,
  output logic                       borrow_o
);
  import wsts_pkg::*;

  logic [SumW:0] full;

  always_comb begin
    unique case (op_i)
      ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = '0;
    endcase
  end

  assign y_o      = full[SumW-1:0];
  assign borrow_o = (op_i == ALU_SUB) && full[SumW];

endmodule

[rtl/wsts_seq.sv]
// ----------------------------------------------------------------------------
// wsts_seq
// Sequencer of the sum-tree sampler: walks the node store one level per
// cycle through the shared add/subtract unit, and sweeps it on clear.
// ----------------------------------------------------------------------------
module wsts_seq #(
  parameter int unsigned LEAVES = wsts_pkg::LeavesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  wsts_pkg::req_t                 req_i,
  input  logic [$clog2(LEAVES+1)-1:0]    count_i,
  input  logic                           out_free_i,
  output logic                           ready_o,
  output logic                           done_o,
  output wsts_pkg::res_t                 res_o
);
  import wsts_pkg::*;

  localparam int unsigned LW    = $clog2(LEAVES);
  localparam int unsigned AW    = LW + 1;
  localparam int unsigned Depth = 2 ** AW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_OLD,
    S_UPD_WALK,
    S_SRCH,
    S_LEAF,
    S_OUT
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        addr_q;
  logic [SumW-1:0]      root_q;
  logic [SumW-1:0]      rem_q;
  logic [SumW-1:0]      diff_q;
  logic [WeightW-1:0]   weight_q;
  logic [LeafW-1:0]     idx_q;
  logic [WeightW-1:0]   wt_q;
  logic                 beyond_q;
  logic                 bad_q;
  logic                 clr_cmd_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SumW-1:0]      ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [SumW-1:0]      ram_rdata;

  alu_op_e              alu_op;
  logic [SumW-1:0]      alu_a;
  logic [SumW-1:0]      alu_b;
  logic [SumW-1:0]      alu_y;
  logic                 alu_borrow;

  logic [31:0]          leaf_ext;
  logic [31:0]          last_ext;
  logic [LW-1:0]        leaf_lw;
  logic [LW-1:0]        last_lw;
  logic [AW-1:0]        leaf_node;
  logic [AW-1:0]        last_node;
  logic                 leaf_bad;
  logic                 go_left;
  logic [AW-1:0]        next_node;
  logic                 reached;
  logic [LW-1:0]        found;
  logic                 srch_bad;

  function automatic logic [LeafW-1:0] to_idx(input logic [LW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[LeafW-1:0];
  endfunction

  wsts_ram #(
    .Width (SumW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wsts_alu u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .y_o      (alu_y),
    .borrow_o (alu_borrow)
  );

  // leaf addressing
  assign leaf_ext  = 32'(req_i.leaf);
  assign last_ext  = 32'(count_i) - 32'd1;
  assign leaf_lw   = leaf_ext[LW-1:0];
  assign last_lw   = last_ext[LW-1:0];
  assign leaf_node = {1'b1, leaf_lw};
  assign last_node = {1'b1, last_lw};
  assign leaf_bad  = leaf_ext >= 32'(count_i);

  // search step
  assign go_left   = alu_borrow || (alu_y == '0);
  assign next_node = {addr_q[AW-2:0], ~go_left};
  assign reached   = next_node[AW-1];
  assign found     = next_node[LW-1:0];
  assign srch_bad  = reached && (32'(found) >= 32'(count_i));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = addr_q;
    alu_op    = ALU_SUB;
    alu_a     = rem_q;
    alu_b     = ram_rdata;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        alu_a = root_q;
        alu_b = req_i.target;
        priority if (req_i.action == ACT_SEARCH) begin
          ram_raddr = alu_borrow ? last_node : AW'(2);
        end else begin
          ram_raddr = leaf_node;
        end
      end
      S_UPD_OLD: begin
        alu_a     = 32'(weight_q);
        ram_we    = 1'b1;
        ram_wdata = 32'(weight_q);
        ram_raddr = addr_q >> 1;
      end
      S_UPD_WALK: begin
        alu_op    = ALU_ADD;
        alu_a     = ram_rdata;
        alu_b     = diff_q;
        ram_we    = 1'b1;
        ram_wdata = alu_y;
        ram_raddr = addr_q >> 1;
      end
      S_SRCH: begin
        priority if (srch_bad) begin
          ram_raddr = last_node;
        end else if (reached) begin
          ram_raddr = next_node;
        end else begin
          ram_raddr = next_node << 1;
        end
      end
      S_LEAF, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      addr_q    <= '0;
      root_q    <= '0;
      clr_cmd_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == '1) begin
            state_q   <= clr_cmd_q ? S_OUT : S_IDLE;
            clr_cmd_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            beyond_q <= 1'b0;
            bad_q    <= 1'b0;
            weight_q <= req_i.weight;
            idx_q    <= req_i.leaf;
            wt_q     <= '0;
            unique case (req_i.action)
              ACT_UPDATE, ACT_READ: begin
                if (leaf_bad) begin
                  bad_q   <= 1'b1;
                  state_q <= S_OUT;
                end else begin
                  addr_q  <= leaf_node;
                  state_q <= (req_i.action == ACT_UPDATE) ? S_UPD_OLD : S_LEAF;
                end
              end
              ACT_SEARCH: begin
                if (alu_borrow) begin
                  beyond_q <= 1'b1;
                  idx_q    <= to_idx(last_lw);
                  state_q  <= S_LEAF;
                end else begin
                  addr_q  <= AW'(1);
                  rem_q   <= req_i.target;
                  state_q <= S_SRCH;
                end
              end
              ACT_CLEAR: begin
                addr_q    <= '0;
                root_q    <= '0;
                idx_q     <= '0;
                clr_cmd_q <= 1'b1;
                state_q   <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_UPD_OLD: begin
          diff_q  <= alu_y;
          wt_q    <= weight_q;
          addr_q  <= addr_q >> 1;
          state_q <= S_UPD_WALK;
        end
        S_UPD_WALK: begin
          if (addr_q == AW'(1)) begin
            root_q  <= alu_y;
            state_q <= S_OUT;
          end else begin
            addr_q <= addr_q >> 1;
          end
        end
        S_SRCH: begin
          if (!go_left) begin
            rem_q <= alu_y;
          end
          addr_q <= next_node;
          if (reached) begin
            idx_q   <= to_idx(srch_bad ? last_lw : found);
            bad_q   <= srch_bad;
            state_q <= S_LEAF;
          end
        end
        S_LEAF: begin
          wt_q    <= ram_rdata[WeightW-1:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign ready_o = (state_q == S_IDLE);
  assign done_o  = (state_q == S_OUT) && out_free_i;

  assign res_o.leaf_index   = idx_q;
  assign res_o.leaf_weight  = wt_q;
  assign res_o.total_sum    = root_q;
  assign res_o.beyond_total = beyond_q;
  assign res_o.bad_index    = bad_q;

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Directed and random update, search, read and clear transfers against the
// sum-tree sampler across several leaf_count settings. Every result is
// checked against a behavioral sum tree kept inside the testbench.
// ----------------------------------------------------------------------------
module testbench;
  import wsts_pkg::*;

  localparam int unsigned Span    = LeavesDef;
  localparam int unsigned WdLimit = 8000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  wsts_item_if   item_if ();
  wsts_result_if res_if ();

  weighted_sum_tree_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (res_if)
  );

  always #2 clk_i = ~clk_i;

  // behavioral tree, node 1 is the root, leaves start at Span
  logic [SumW-1:0]    tree_sums [1:2*Span-1];
  logic [CountW-1:0]  tree_count;

  // running leaf weights on the stimulus side, used to aim search targets
  logic [WeightW-1:0] gen_w [Span];
  logic [SumW-1:0]    gen_total;
  int unsigned        gen_active;

  req_t        pend_q [$];
  res_t        tree_results_q [$];
  req_t        next_req;
  res_t        got, want;
  int unsigned queued_cnt, done_cnt, err_cnt, wd_cnt;
  int unsigned src_gap, snk_gap;
  bit          idle_en;

  function automatic int unsigned active_leaves(logic [CountW-1:0] c);
    if (c == 0) return 1;
    if (c > Span) return Span;
    return c;
  endfunction

  function automatic res_t sample_tree(req_t rq);
    res_t            r;
    int unsigned     n, i, found;
    logic [SumW-1:0] diff, rem;
    r = '0;
    n = active_leaves(tree_count);
    case (rq.action)
      ACT_UPDATE, ACT_READ: begin
        r.leaf_index = rq.leaf;
        if (rq.leaf >= n) begin
          r.bad_index = 1'b1;
        end else if (rq.action == ACT_UPDATE) begin
          i = Span + rq.leaf;
          diff = rq.weight - tree_sums[i];
          while (i >= 1) begin
            tree_sums[i] += diff;
            i >>= 1;
          end
          r.leaf_weight = rq.weight;
        end else begin
          r.leaf_weight = tree_sums[Span + rq.leaf][WeightW-1:0];
        end
      end
      ACT_SEARCH: begin
        if (rq.target > tree_sums[1]) begin
          r.beyond_total = 1'b1;
          found = n - 1;
        end else begin
          i = 1;
          rem = rq.target;
          while (i < Span) begin
            if (rem <= tree_sums[2*i]) begin
              i = 2 * i;
            end else begin
              rem -= tree_sums[2*i];
              i = 2 * i + 1;
            end
          end
          found = i - Span;
          if (found >= n) begin
            r.bad_index = 1'b1;
            found = n - 1;
          end
        end
        r.leaf_index = found[LeafW-1:0];
        r.leaf_weight = tree_sums[Span + found][WeightW-1:0];
      end
      default: begin
        foreach (tree_sums[k]) tree_sums[k] = '0;
      end
    endcase
    r.total_sum = tree_sums[1];
    return r;
  endfunction

  task automatic put_req(action_e a, int unsigned lf, int unsigned w, logic [SumW-1:0] t);
    req_t rq;
    rq.action = a;
    rq.leaf   = lf[LeafW-1:0];
    rq.weight = w[WeightW-1:0];
    rq.target = t;
    pend_q.push_back(rq);
    queued_cnt++;
    case (a)
      ACT_UPDATE: begin
        if (rq.leaf < gen_active) begin
          gen_total = gen_total - gen_w[rq.leaf] + rq.weight;
          gen_w[rq.leaf] = rq.weight;
        end
      end
      ACT_CLEAR: begin
        foreach (gen_w[k]) gen_w[k] = '0;
        gen_total = '0;
      end
      default: ;
    endcase
  endtask

  task automatic rand_reqs(int unsigned cnt);
    int unsigned     pick, lf, w;
    logic [SumW-1:0] t;
    action_e         a;
    repeat (cnt) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) a = ACT_UPDATE;
      else if (pick < 78) a = ACT_SEARCH;
      else if (pick < 96) a = ACT_READ;
      else a = ACT_CLEAR;
      if ($urandom_range(0, 4) == 0) lf = $urandom_range(0, Span - 1);
      else lf = $urandom_range(0, gen_active - 1);
      case ($urandom_range(0, 5))
        0: w = 0;
        1: w = 24'hFFFFFF;
        2: w = $urandom_range(1, 15);
        default: w = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: t = gen_total;
        1: t = gen_total + 1;
        2: t = $urandom;
        3: t = '0;
        default: t = $urandom_range(0, gen_total);
      endcase
      put_req(a, lf, w, t);
    end
  endtask

  task automatic set_count(int unsigned c);
    while (done_cnt != queued_cnt) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c[CountW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tree_count = c[CountW-1:0];
    gen_active = active_leaves(c[CountW-1:0]);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid  <= 1'b0;
      item_if.action <= ACT_READ;
      item_if.leaf   <= '0;
      item_if.weight <= '0;
      item_if.target <= '0;
      foreach (tree_sums[k]) tree_sums[k] = '0;
      src_gap = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        tree_results_q.push_back(sample_tree(req_t'{item_if.action, item_if.leaf,
                                                    item_if.weight, item_if.target}));
        if (idle_en && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 14);
      end
      if (!item_if.valid || item_if.ready) begin
        if (src_gap != 0 || pend_q.size() == 0) begin
          item_if.valid <= 1'b0;
          if (src_gap != 0) src_gap--;
        end else begin
          next_req = pend_q.pop_front();
          item_if.valid  <= 1'b1;
          item_if.action <= next_req.action;
          item_if.leaf   <= next_req.leaf;
          item_if.weight <= next_req.weight;
          item_if.target <= next_req.target;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.leaf_index, res_if.leaf_weight, res_if.total_sum,
                res_if.beyond_total, res_if.bad_index};
        if (tree_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected transfer: idx %0d w %h sum %h beyond %b bad %b",
                     got.leaf_index, got.leaf_weight, got.total_sum,
                     got.beyond_total, got.bad_index);
        end else begin
          want = tree_results_q.pop_front();
          done_cnt++;
          if (got.leaf_index !== want.leaf_index || got.leaf_weight !== want.leaf_weight ||
              got.total_sum !== want.total_sum || got.beyond_total !== want.beyond_total ||
              got.bad_index !== want.bad_index) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp %0d %h %h %b %b / got %0d %h %h %b %b",
                       want.leaf_index, want.leaf_weight, want.total_sum,
                       want.beyond_total, want.bad_index,
                       got.leaf_index, got.leaf_weight, got.total_sum,
                       got.beyond_total, got.bad_index);
          end
        end
      end
      if (snk_gap != 0) begin
        res_if.ready <= 1'b0;
        snk_gap--;
      end else begin
        res_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 11) == 0) snk_gap = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WdLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = CountRst;
    idle_en        = 1'b1;
    foreach (gen_w[k]) gen_w[k] = '0;
    tree_count = CountRst;
    gen_total  = '0;
    gen_active = Span;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty tree
    put_req(ACT_READ,   0,   0,          32'd0);
    put_req(ACT_SEARCH, 0,   0,          32'd0);
    put_req(ACT_SEARCH, 0,   0,          32'd1);
    // both ends at full weight and the middle at weight 1
    put_req(ACT_UPDATE, 0,   24'hFFFFFF, 32'd0);
    put_req(ACT_UPDATE, 255, 24'hFFFFFF, 32'd0);
    put_req(ACT_UPDATE, 128, 1,          32'd0);
    put_req(ACT_READ,   255, 0,          32'd0);
    put_req(ACT_SEARCH, 0,   0,          32'd0);
    put_req(ACT_SEARCH, 0,   0,          32'h00FFFFFF);
    put_req(ACT_SEARCH, 0,   0,          32'h01000000);
    put_req(ACT_SEARCH, 0,   0,          32'h01FFFFFF);
    put_req(ACT_SEARCH, 0,   0,          32'h02000000);
    put_req(ACT_SEARCH, 0,   0,          32'hFFFFFFFF);
    // lowered weight
    put_req(ACT_UPDATE, 0,   0,          32'd0);
    put_req(ACT_SEARCH, 0,   0,          32'd1);
    put_req(ACT_CLEAR,  255, 24'hFFFFFF, 32'hFFFFFFFF);
    put_req(ACT_READ,   255, 0,          32'd0);
    put_req(ACT_UPDATE, 200, 50,         32'd0);
    // weight left above the active leaves
    set_count(100);
    put_req(ACT_SEARCH, 0,   0,          32'd10);
    put_req(ACT_SEARCH, 0,   0,          32'd51);
    put_req(ACT_UPDATE, 100, 5,          32'd0);
    set_count(1);
    put_req(ACT_UPDATE, 1,   7,          32'd0);
    put_req(ACT_UPDATE, 0,   7,          32'd0);
    put_req(ACT_SEARCH, 0,   0,          32'd3);

    set_count(0);
    rand_reqs(60);
    set_count(511);
    rand_reqs(70);
    set_count(257);
    rand_reqs(60);
    set_count($urandom_range(2, 255));
    rand_reqs(70);
    set_count(1);
    rand_reqs(30);
    set_count(256);
    idle_en = 1'b0;
    rand_reqs(110);

    while (done_cnt != queued_cnt) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/wsts_pkg.sv
rtl/wsts_item_if.sv
rtl/wsts_result_if.sv
rtl/wsts_ram.sv
rtl/wsts_alu.sv
rtl/wsts_seq.sv
rtl/weighted_sum_tree_sampler.sv
verif/testbench.sv
